@@ design/dq_pkg.sv @@
`timescale 1ns / 1ps

package dq_pkg;

    // Command codes carried on the func field.
    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_PEEK_FRONT = 3'd4,
        FN_PEEK_BACK  = 3'd5,
        FN_CLEAR      = 3'd6
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DATA  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Port width of the data words on both channels.
    localparam int PORT_WIDTH = 32;

    // Access issued to the entry store for one transaction.
    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_cmd;

endpackage

@@ design/dq_ctrl.sv @@
`timescale 1ns / 1ps

module dq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [2:0]        i_func,
    output logic [AW-1:0]     o_addr,
    output dq_pkg::t_mem_cmd  o_cmd,
    output dq_pkg::t_status   o_status,
    output logic [CW-1:0]     o_level
);
    import dq_pkg::*;

    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;

    logic          full, empty;
    logic [AW-1:0] head_dec, head_inc;
    logic [SW-1:0] sum_next, sum_last;
    logic [AW-1:0] pos_next, pos_last;
    t_func         func;

    assign func  = t_func'(i_func);
    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    // Neighbor positions of the front word, wrapping at the store depth.
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Slot after the back word and the back word itself; if nonempty, both sums stay below twice the depth.
    assign sum_next = SW'(r_head) + SW'(r_count);
    assign sum_last = sum_next - 1'b1;
    assign pos_next = (sum_next >= DEPTH_S) ? AW'(sum_next - DEPTH_S) : AW'(sum_next);
    assign pos_last = (sum_last >= DEPTH_S) ? AW'(sum_last - DEPTH_S) : AW'(sum_last);

    // Decode the command into a store access, a status and the pointer update.
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        o_addr   = r_head;
        o_cmd    = '0;
        o_status = ST_OK;
        case (func)
            FN_PUSH_FRONT: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_cmd.wr = 1'b1;
                    o_addr   = head_dec;
                    n_head   = head_dec;
                    n_count  = r_count + 1'b1;
                end
            end
            FN_PUSH_BACK: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_cmd.wr = 1'b1;
                    o_addr   = pos_next;
                    n_count  = r_count + 1'b1;
                end
            end
            FN_POP_FRONT, FN_PEEK_FRONT: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else begin
                    o_cmd.rd = 1'b1;
                    o_addr   = r_head;
                    o_status = ST_DATA;
                    if (func == FN_POP_FRONT) begin
                        n_head  = head_inc;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            FN_POP_BACK, FN_PEEK_BACK: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else begin
                    o_cmd.rd = 1'b1;
                    o_addr   = pos_last;
                    o_status = ST_DATA;
                    if (func == FN_POP_BACK) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            FN_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (!i_accept) begin
            o_cmd   = '0;
            n_head  = r_head;
            n_count = r_count;
        end
    end

    // Pointer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    assign o_level = r_count;

endmodule

@@ design/dq_store.sv @@
`timescale 1ns / 1ps

module dq_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 4
) (
    input  logic                         i_clk,
    input  dq_pkg::t_mem_cmd             i_cmd,
    input  logic [AW-1:0]                i_addr,
    input  logic [dq_pkg::PORT_WIDTH-1:0] i_value,
    output logic [DATA_WIDTH-1:0]        o_rd_data
);
    import dq_pkg::*;

    // Bits of the port word that the store can hold.
    localparam int KW = (DATA_WIDTH < PORT_WIDTH) ? DATA_WIDTH : PORT_WIDTH;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [DATA_WIDTH-1:0] wr_word;

    assign wr_word = DATA_WIDTH'(i_value[KW-1:0]);

    // Single-port store with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_addr] <= wr_word;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/dq_out.sv @@
`timescale 1ns / 1ps

module dq_out #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  dq_pkg::t_status               i_status,
    input  logic [DATA_WIDTH-1:0]         i_rd_data,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [dq_pkg::PORT_WIDTH-1:0] o_data_out,
    output logic                          o_free
);
    import dq_pkg::*;

    localparam int KW = (DATA_WIDTH < PORT_WIDTH) ? DATA_WIDTH : PORT_WIDTH;

    logic            r_s2_valid, n_s2_valid;
    t_status         r_s2_status;
    logic            r_valid, n_valid;
    t_status         r_status;
    logic [PORT_WIDTH-1:0] r_data;
    logic            s2_move;

    // The read stage advances whenever the output register is empty or being drained.
    assign s2_move    = r_s2_valid && (!r_valid || !i_stall);
    assign o_free     = !r_s2_valid || s2_move;
    assign n_s2_valid = i_accept || (r_s2_valid && !s2_move);
    assign n_valid    = s2_move || (r_valid && i_stall);

    // Control state of the read stage and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_s2_valid <= n_s2_valid;
            r_valid    <= n_valid;
        end
    end

    // Payload: status waits beside the store read, then joins the data word.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s2_status <= i_status;
        end
        if (s2_move) begin
            r_status <= r_s2_status;
            r_data   <= (r_s2_status == ST_DATA) ? PORT_WIDTH'(i_rd_data[KW-1:0]) : '0;
        end
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_data_out = r_data;

endmodule

@@ design/double_ended_queue_core.sv @@
// Double-ended queue in a single-port circular store.
// Results: an accepted command's result passes the store read register, then the output register.
// Throughput: one command per cycle while o_stall is low; the store takes one read or one write per cycle.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// stored words are not cleared and are never read before being written.
`timescale 1ns / 1ps

module double_ended_queue_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_data_out
);
    import dq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic          accept;
    logic          free;
    logic [AW-1:0] addr;
    t_mem_cmd      cmd;
    t_status       status;
    logic [CW-1:0] level;
    logic [DATA_WIDTH-1:0] rd_data;

    // A command is taken once the read stage can hand on its result.
    assign o_stall = !free;
    assign accept  = i_valid && free;

    dq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_func   (i_func),
        .o_addr   (addr),
        .o_cmd    (cmd),
        .o_status (status),
        .o_level  (level)
    );

    dq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_addr    (addr),
        .i_value   (i_value),
        .o_rd_data (rd_data)
    );

    dq_out #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_status   (status),
        .i_rd_data  (rd_data),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_data_out (o_data_out),
        .o_free     (free)
    );

    // The fill level never passes the store depth.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= CW'(DEPTH))
        else $error("queue level exceeds depth");

    // A clear transaction leaves the queue empty.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_func == FN_CLEAR) |=> level == '0)
        else $error("clear did not empty the queue");

    // Only a data result carries a nonzero word.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_DATA) |-> o_data_out == '0)
        else $error("nonzero data on a result without data");

    // The store is never read and written by the same transaction.
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr && cmd.rd))
        else $error("store read and write issued together");

endmodule

@@ verif/double_ended_queue_core_tb.sv @@
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
    import dq_pkg::*;

    localparam int DEPTH = 16;
    localparam int DATA_WIDTH = 32;
    localparam logic [2:0] FN_UNDEFINED = 3'd7;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_CMDS = 600;

    // One command transaction as offered to the block.
    typedef struct {
        logic [2:0]  func;
        logic [31:0] value;
    } t_deque_cmd;

    // One result transaction as expected from the block.
    typedef struct {
        t_status     status;
        logic [31:0] data;
    } t_deque_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [2:0]  i_func = 3'd0;
    logic [31:0] i_value = 32'd0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_data_out;

    // Commands waiting to be driven and results waiting to be seen.
    t_deque_cmd    pending_cmds[$];
    t_deque_result expected_results[$];

    // Shadow copy of the queue contents.
    logic [DATA_WIDTH-1:0] shadow_words[DEPTH];
    logic [3:0]            shadow_head;
    logic [4:0]            shadow_count;

    int error_count = 0;
    int total_cmds = 0;
    int cmds_accepted = 0;
    int burst_left = 0;
    int gap_left = 0;
    int idle_cycles = 0;
    int results_taken = 0;
    int hold_left = 0;
    int holds_done = 0;
    int rx_phase = 0;
    int rx_phase_left = 0;
    t_deque_cmd next_cmd;

    double_ended_queue_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_func     (i_func),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_data_out (o_data_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic add_cmd(input logic [2:0] func, input logic [31:0] value);
        t_deque_cmd cmd;
        cmd.func = func;
        cmd.value = value;
        pending_cmds.push_back(cmd);
    endtask

    // Mostly random words, with all-zero and all-one words mixed in.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Applies one accepted command to the shadow queue and records its result.
    task automatic deque_apply(input logic [2:0] func, input logic [31:0] value);
        t_deque_result res;
        logic [3:0]    pos;
        res.status = ST_OK;
        res.data = '0;
        case (func)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    if (func == FN_PUSH_FRONT) begin
                        shadow_head = shadow_head - 4'd1;
                        pos = shadow_head;
                    end else begin
                        pos = shadow_head + shadow_count[3:0];
                    end
                    shadow_words[pos] = value[DATA_WIDTH-1:0];
                    shadow_count++;
                end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    if (func == FN_POP_BACK || func == FN_PEEK_BACK)
                        pos = shadow_head + shadow_count[3:0] - 4'd1;
                    else
                        pos = shadow_head;
                    res.data = shadow_words[pos];
                    res.status = ST_DATA;
                    if (func == FN_POP_FRONT) begin
                        shadow_head = shadow_head + 4'd1;
                        shadow_count--;
                    end else if (func == FN_POP_BACK) begin
                        shadow_count--;
                    end
                end
            end
            FN_CLEAR: begin
                shadow_head = '0;
                shadow_count = '0;
            end
            default: begin
            end
        endcase
        expected_results.push_back(res);
    endtask

    // Driver: offers queued commands in bursts separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                deque_apply(i_func, i_value);
                cmds_accepted++;
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    next_cmd = pending_cmds.pop_front();
                    i_valid <= 1'b1;
                    i_func <= next_cmd.func;
                    i_value <= next_cmd.value;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls on its own phased pattern, with two long hold-offs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                results_taken++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (holds_done < 2 && results_taken >= 120 + holds_done * 280) begin
                holds_done++;
                hold_left = 60;
                i_stall <= 1'b1;
            end else begin
                if (rx_phase_left == 0) begin
                    rx_phase = $urandom_range(0, 3);
                    rx_phase_left = $urandom_range(10, 80);
                end else begin
                    rx_phase_left--;
                end
                case (rx_phase)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    // Monitor: checks every result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d data=%08h",
                                          o_status, o_data_out));
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                if (o_data_out !== want.data)
                    report_mismatch($sformatf("data_out %08h, expected %08h",
                                              o_data_out, want.data));
            end
        end
    end

    // Watchdog: ends the run if no transaction moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("double_ended_queue_core regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int gen_count;
        int fill_mode;
        int push_pct;
        int mode_left;
        int pick;
        logic [2:0] func;

        shadow_head = '0;
        shadow_count = '0;
        for (int i = 0; i < DEPTH; i++)
            shadow_words[i] = '0;

        // Directed: reads while empty, the undefined command, a fill to
        // capacity, pushes while full, then a clear followed by a read.
        add_cmd(FN_PEEK_FRONT, 32'h0);
        add_cmd(FN_PEEK_BACK, 32'hFFFF_FFFF);
        add_cmd(FN_POP_FRONT, 32'h0);
        add_cmd(FN_POP_BACK, 32'hFFFF_FFFF);
        add_cmd(FN_UNDEFINED, 32'h1234_5678);
        for (int i = 0; i < DEPTH; i++) begin
            case (i % 4)
                0: add_cmd(FN_PUSH_FRONT, 32'h0000_0000);
                1: add_cmd(FN_PUSH_BACK, 32'hFFFF_FFFF);
                2: add_cmd(FN_PUSH_FRONT, 32'h1 << i);
                default: add_cmd(FN_PUSH_BACK, ~(32'h1 << (i + 16)));
            endcase
        end
        add_cmd(FN_PUSH_FRONT, 32'hA5A5_A5A5);
        add_cmd(FN_PUSH_BACK, 32'h5A5A_5A5A);
        add_cmd(FN_CLEAR, 32'h0);
        add_cmd(FN_POP_BACK, 32'h0);

        // Random: alternating fill and drain phases so the queue hits both
        // full and empty and the pointers wrap, with clears and noise.
        gen_count = 0;
        fill_mode = 1;
        mode_left = $urandom_range(20, 60);
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (mode_left == 0) begin
                fill_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 60);
            end else begin
                mode_left--;
            end
            if (fill_mode == 1 && gen_count >= DEPTH && $urandom_range(0, 3) == 0)
                fill_mode = 0;
            else if (fill_mode == 0 && gen_count == 0 && $urandom_range(0, 3) == 0)
                fill_mode = 1;
            push_pct = (fill_mode == 1) ? 70 : (fill_mode == 0) ? 25 : 47;
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                func = FN_CLEAR;
                gen_count = 0;
            end else if (pick < 3) begin
                func = FN_UNDEFINED;
            end else if (pick < 3 + push_pct) begin
                func = ($urandom_range(0, 1) == 0) ? FN_PUSH_FRONT : FN_PUSH_BACK;
                if (gen_count < DEPTH)
                    gen_count++;
            end else begin
                case ($urandom_range(0, 3))
                    0: func = FN_POP_FRONT;
                    1: func = FN_POP_BACK;
                    2: func = FN_PEEK_FRONT;
                    default: func = FN_PEEK_BACK;
                endcase
                if ((func == FN_POP_FRONT || func == FN_POP_BACK) && gen_count > 0)
                    gen_count--;
            end
            add_cmd(func, pick_word());
        end
        total_cmds = pending_cmds.size();

        // Reset, then let the driver and monitor run.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_accepted < total_cmds || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_results.size()));
        if (error_count == 0) begin
            $display("double_ended_queue_core regression: pass");
        end else begin
            $display("double_ended_queue_core regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/dq_pkg.sv
design/dq_ctrl.sv
design/dq_store.sv
design/dq_out.sv
design/double_ended_queue_core.sv
verif/double_ended_queue_core_tb.sv
